### hdl/ngga_pkg.sv
// Shared types, character codes and lookup functions for the GGA position parser.
package ngga_pkg;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;

  // Header match positions ("$" is position 0)
  localparam logic [2:0] HDR_FIRST = 3'd1;
  localparam logic [2:0] HDR_LAST  = 3'd5;

  // Field numbers on a GGA line
  localparam logic [3:0] FLD_LAT      = 4'd2;
  localparam logic [3:0] FLD_LAT_HEM  = 4'd3;
  localparam logic [3:0] FLD_LNG      = 4'd4;
  localparam logic [3:0] FLD_LNG_HEM  = 4'd5;
  localparam logic [3:0] FLD_MIN_EMIT = 4'd5;
  localparam logic [3:0] FLD_MAX      = 4'd15;

  // Fraction digits kept per numeric field (1..6)
  localparam logic [2:0] FRAC_DIGITS = 3'd5;

  localparam logic [33:0] ACC_MAX = 34'h3_FFFF_FFFF;
  localparam logic [31:0] LAT_LIM = 32'd900000000;
  localparam logic [31:0] LNG_LIM = 32'd1800000000;
  localparam logic [31:0] E7      = 32'd10000000;
  // ceil(2^35 / 15): x / 15 == (x * RECIP15) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP15 = 32'h8888_8889;

  // Values gathered on one line, handed to the converter at end of line
  typedef struct packed {
    logic [33:0] lat_acc;
    logic [2:0]  lat_cnt;
    logic        lat_neg;
    logic [33:0] lng_acc;
    logic [2:0]  lng_cnt;
    logic        lng_neg;
  } ngga_job_t;

  // One channel in the degree divider
  typedef struct packed {
    logic [33:0] rem;
    logic [26:0] dvs;
    logic [7:0]  quo;
    logic [2:0]  cnt;
    logic        sat;
    logic        neg;
  } ngga_div_t;

  // One channel after the minutes scaling multiply
  typedef struct packed {
    logic [29:0] prod;
    logic [31:0] dp;
    logic        sat;
    logic        neg;
  } ngga_mul_t;

  // One channel after the divide by 60
  typedef struct packed {
    logic [24:0] mp;
    logic [31:0] dp;
    logic        sat;
    logic        neg;
  } ngga_fin_t;

  function automatic logic [7:0] hdr_char_f(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd1:    c = CH_G;
      3'd2:    c = CH_P;
      3'd3:    c = CH_G;
      3'd4:    c = CH_G;
      3'd5:    c = CH_A;
      default: c = CH_DOLLAR;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] pow10_f(input logic [2:0] n);
    logic [23:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  // One whole degree in accumulator units: 100 * 10^cnt
  function automatic logic [26:0] dvs_f(input logic [2:0] cnt);
    logic [26:0] d;
    case (cnt)
      3'd0:    d = 27'd100;
      3'd1:    d = 27'd1000;
      3'd2:    d = 27'd10000;
      3'd3:    d = 27'd100000;
      3'd4:    d = 27'd1000000;
      3'd5:    d = 27'd10000000;
      default: d = 27'd100000000;
    endcase
    return d;
  endfunction

endpackage

### hdl/ngga_parser.sv
// Byte-wise line parser: header match, field count, digit and hemisphere capture.
module ngga_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output logic                job_valid,
  output ngga_pkg::ngga_job_t job
);

  typedef struct packed {
    logic [33:0] acc;
    logic [2:0]  cnt;
  } num_t;

  logic [2:0]  hdr_pos_r, hdr_pos_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [3:0]  fld_r, fld_nxt;
  logic [33:0] lat_acc_r, lat_acc_nxt;
  logic [2:0]  lat_cnt_r, lat_cnt_nxt;
  logic        lat_s_r, lat_s_nxt;
  logic [33:0] lng_acc_r, lng_acc_nxt;
  logic [2:0]  lng_cnt_r, lng_cnt_nxt;
  logic        lng_w_r, lng_w_nxt;
  logic        pt_r, pt_nxt;
  logic        is_digit;
  num_t        lat_num, lng_num;

  // acc*10 + digit, saturating; fraction digits past the limit are dropped
  function automatic num_t digit_f(input logic [33:0] acc, input logic [2:0] cnt,
                                   input logic pt, input logic [7:0] c);
    num_t        r;
    logic [37:0] v;
    r.acc = acc;
    r.cnt = cnt;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {34'b0, c[3:0]};
    if (!(pt && (cnt >= ngga_pkg::FRAC_DIGITS))) begin
      if (pt) begin
        r.cnt = cnt + 3'd1;
      end
      r.acc = (|v[37:34]) ? ngga_pkg::ACC_MAX : v[33:0];
    end
    return r;
  endfunction

  assign is_digit = (rx_byte >= ngga_pkg::CH_ZERO) && (rx_byte <= ngga_pkg::CH_NINE);
  assign lat_num  = digit_f(lat_acc_r, lat_cnt_r, pt_r, rx_byte);
  assign lng_num  = digit_f(lng_acc_r, lng_cnt_r, pt_r, rx_byte);

  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    hdr_ok_nxt  = hdr_ok_r;
    fld_nxt     = fld_r;
    lat_acc_nxt = lat_acc_r;
    lat_cnt_nxt = lat_cnt_r;
    lat_s_nxt   = lat_s_r;
    lng_acc_nxt = lng_acc_r;
    lng_cnt_nxt = lng_cnt_r;
    lng_w_nxt   = lng_w_r;
    pt_nxt      = pt_r;
    job_valid   = 1'b0;
    if (fire) begin
      if (rx_byte == ngga_pkg::CH_DOLLAR) begin
        hdr_pos_nxt = ngga_pkg::HDR_FIRST;
        hdr_ok_nxt  = 1'b0;
        fld_nxt     = '0;
        lat_acc_nxt = '0;
        lat_cnt_nxt = '0;
        lat_s_nxt   = 1'b1;
        lng_acc_nxt = '0;
        lng_cnt_nxt = '0;
        lng_w_nxt   = 1'b1;
        pt_nxt      = 1'b0;
      end else if ((rx_byte == ngga_pkg::CH_CR) || (rx_byte == ngga_pkg::CH_LF)) begin
        job_valid   = hdr_ok_r && (fld_r >= ngga_pkg::FLD_MIN_EMIT);
        hdr_ok_nxt  = 1'b0;
        hdr_pos_nxt = '0;
      end else if (!hdr_ok_r) begin
        if ((hdr_pos_r >= ngga_pkg::HDR_FIRST) && (hdr_pos_r <= ngga_pkg::HDR_LAST) &&
            (rx_byte == ngga_pkg::hdr_char_f(hdr_pos_r))) begin
          hdr_pos_nxt = hdr_pos_r + 3'd1;
          if (hdr_pos_r == ngga_pkg::HDR_LAST) begin
            hdr_ok_nxt = 1'b1;
          end
        end else begin
          hdr_pos_nxt = '0;
        end
      end else if (rx_byte == ngga_pkg::CH_COMMA) begin
        if (fld_r != ngga_pkg::FLD_MAX) begin
          fld_nxt = fld_r + 4'd1;
        end
        pt_nxt = 1'b0;
      end else begin
        case (fld_r)
          ngga_pkg::FLD_LAT: begin
            if (rx_byte == ngga_pkg::CH_POINT) begin
              pt_nxt = 1'b1;
            end else if (is_digit) begin
              lat_acc_nxt = lat_num.acc;
              lat_cnt_nxt = lat_num.cnt;
            end
          end
          ngga_pkg::FLD_LAT_HEM: begin
            if (!pt_r) begin
              lat_s_nxt = (rx_byte != ngga_pkg::CH_N);
              pt_nxt    = 1'b1;
            end
          end
          ngga_pkg::FLD_LNG: begin
            if (rx_byte == ngga_pkg::CH_POINT) begin
              pt_nxt = 1'b1;
            end else if (is_digit) begin
              lng_acc_nxt = lng_num.acc;
              lng_cnt_nxt = lng_num.cnt;
            end
          end
          ngga_pkg::FLD_LNG_HEM: begin
            if (!pt_r) begin
              lng_w_nxt = (rx_byte != ngga_pkg::CH_E);
              pt_nxt    = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= '0;
      hdr_ok_r  <= 1'b0;
      fld_r     <= '0;
      lat_acc_r <= '0;
      lat_cnt_r <= '0;
      lat_s_r   <= 1'b0;
      lng_acc_r <= '0;
      lng_cnt_r <= '0;
      lng_w_r   <= 1'b0;
      pt_r      <= 1'b0;
    end else begin
      hdr_pos_r <= hdr_pos_nxt;
      hdr_ok_r  <= hdr_ok_nxt;
      fld_r     <= fld_nxt;
      lat_acc_r <= lat_acc_nxt;
      lat_cnt_r <= lat_cnt_nxt;
      lat_s_r   <= lat_s_nxt;
      lng_acc_r <= lng_acc_nxt;
      lng_cnt_r <= lng_cnt_nxt;
      lng_w_r   <= lng_w_nxt;
      pt_r      <= pt_nxt;
    end
  end

  assign job.lat_acc = lat_acc_r;
  assign job.lat_cnt = lat_cnt_r;
  assign job.lat_neg = lat_s_r;
  assign job.lng_acc = lng_acc_r;
  assign job.lng_cnt = lng_cnt_r;
  assign job.lng_neg = lng_w_r;

endmodule

### hdl/ngga_conv.sv
// Pipelined conversion of gathered ddmm.mmmmm values to signed 1e-7 degrees.
module ngga_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  ngga_pkg::ngga_job_t job,
  output logic                job_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [30:0]         lat,
  output logic [31:0]         lng
);

  // Stage map: job, divider setup, eight quotient bits, multiply, /60, final
  localparam int S_JOB  = 0;
  localparam int S_INI  = 1;
  localparam int S_DIV0 = 2;
  localparam int N_DIV  = 8;
  localparam int S_MUL  = S_DIV0 + N_DIV;
  localparam int S_D15  = S_MUL + 1;
  localparam int S_FIN  = S_D15 + 1;
  localparam int N_STG  = S_FIN + 1;

  logic [N_STG-1:0]    v_r;
  logic [N_STG:0]      rdy;
  ngga_pkg::ngga_job_t job_r;
  ngga_pkg::ngga_div_t lat_div_r [0:N_DIV];
  ngga_pkg::ngga_div_t lng_div_r [0:N_DIV];
  ngga_pkg::ngga_mul_t lat_mul_r, lng_mul_r;
  ngga_pkg::ngga_fin_t lat_fin_r, lng_fin_r;
  logic [31:0]         lat_val, lng_val;
  logic [30:0]         lat_r;
  logic [31:0]         lng_r;

  function automatic ngga_pkg::ngga_div_t init_f(input logic [33:0] acc,
                                                 input logic [2:0] cnt, input logic neg);
    ngga_pkg::ngga_div_t d;
    logic [34:0]         top;
    d.rem = acc;
    d.dvs = ngga_pkg::dvs_f(cnt);
    d.quo = '0;
    d.cnt = cnt;
    d.neg = neg;
    top   = {d.dvs, 8'b0};
    // saturated accumulator or 256 degrees and up: result is the limit
    d.sat = (acc == ngga_pkg::ACC_MAX) || ({1'b0, acc} >= top);
    return d;
  endfunction

  // restoring step for quotient bit k
  function automatic ngga_pkg::ngga_div_t step_f(input ngga_pkg::ngga_div_t d,
                                                 input logic [2:0] k);
    ngga_pkg::ngga_div_t r;
    logic [34:0]         sh;
    r  = d;
    sh = {8'b0, d.dvs} << k;
    if ({1'b0, d.rem} >= sh) begin
      r.rem    = d.rem - sh[33:0];
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  // leftover minutes * 10^(7-cnt); whole degrees * 1e7
  function automatic ngga_pkg::ngga_mul_t mul_f(input ngga_pkg::ngga_div_t d);
    ngga_pkg::ngga_mul_t m;
    logic [50:0]         p;
    p      = {24'b0, d.rem[26:0]} * {27'b0, ngga_pkg::pow10_f(3'd7 - d.cnt)};
    m.prod = p[29:0];
    m.dp   = {24'b0, d.quo} * ngga_pkg::E7;
    m.sat  = d.sat;
    m.neg  = d.neg;
    return m;
  endfunction

  // divide by 60 as a shift by 2 and a reciprocal multiply by 1/15
  function automatic ngga_pkg::ngga_fin_t d15_f(input ngga_pkg::ngga_mul_t m);
    ngga_pkg::ngga_fin_t f;
    logic [63:0]         p;
    p     = {36'b0, m.prod[29:2]} * {32'b0, ngga_pkg::RECIP15};
    f.mp  = p[59:35];
    f.dp  = m.dp;
    f.sat = m.sat;
    f.neg = m.neg;
    return f;
  endfunction

  function automatic logic [31:0] fin_f(input ngga_pkg::ngga_fin_t f, input logic [31:0] lim);
    logic [32:0] mag;
    logic [31:0] mc;
    mag = {1'b0, f.dp} + {8'b0, f.mp};
    if (f.sat || (mag > {1'b0, lim})) begin
      mc = lim;
    end else begin
      mc = mag[31:0];
    end
    return f.neg ? (32'd0 - mc) : mc;
  endfunction

  // a stage loads when it is empty or its item moves on
  always_comb begin
    rdy[N_STG] = res_ready;
    for (int i = N_STG - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign job_ready = rdy[S_JOB];
  assign lat_val   = fin_f(lat_fin_r, ngga_pkg::LAT_LIM);
  assign lng_val   = fin_f(lng_fin_r, ngga_pkg::LNG_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[S_JOB]) begin
        v_r[S_JOB] <= job_valid;
      end
      for (int i = S_INI; i < N_STG; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_JOB]) begin
      job_r <= job;
    end
    if (rdy[S_INI]) begin
      lat_div_r[0] <= init_f(job_r.lat_acc, job_r.lat_cnt, job_r.lat_neg);
      lng_div_r[0] <= init_f(job_r.lng_acc, job_r.lng_cnt, job_r.lng_neg);
    end
    for (int j = 0; j < N_DIV; j++) begin
      if (rdy[S_DIV0+j]) begin
        lat_div_r[j+1] <= step_f(lat_div_r[j], 3'(N_DIV - 1 - j));
        lng_div_r[j+1] <= step_f(lng_div_r[j], 3'(N_DIV - 1 - j));
      end
    end
    if (rdy[S_MUL]) begin
      lat_mul_r <= mul_f(lat_div_r[N_DIV]);
      lng_mul_r <= mul_f(lng_div_r[N_DIV]);
    end
    if (rdy[S_D15]) begin
      lat_fin_r <= d15_f(lat_mul_r);
      lng_fin_r <= d15_f(lng_mul_r);
    end
    if (rdy[S_FIN]) begin
      lat_r <= lat_val[30:0];
      lng_r <= lng_val;
    end
  end

  assign res_valid = v_r[S_FIN];
  assign lat       = lat_r;
  assign lng       = lng_r;

endmodule

### hdl/nmea_gga_position_parser_unit.sv
// Top level of the GGA position parser: byte stream in, signed position beats out.
//
// Takes one ASCII character per in_ beat from a GPS receiver, one beat per clock when
// the result side keeps up. Lines starting with "$GPGGA" are parsed field by field,
// empty fields counted; latitude (ddmm.mmmmm, field 2, hemisphere field 3) and
// longitude (dddmm.mmmmm, field 4, hemisphere field 5) are gathered as scaled integers,
// fraction digits past the fifth dropped. A CR or LF that ends a GGA line with at least
// five commas produces one out_ beat: degrees plus minutes/60 in units of 1e-7 degree,
// negative unless the hemisphere letter is N / E, clamped to 90 / 180 degrees. Any other
// line end gives nothing, so a CR LF pair yields one beat. Each emitted line is converted by
// the 13-stage conversion pipeline: a divider resolving one bit of whole degrees per
// stage, a minutes multiply and a reciprocal divide by 60. The per-byte accumulator
// update is registered, and in_tready stays high unless all 13 pipeline stages hold
// results while the output waits.
module nmea_gga_position_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [30:0] latitude, [62:31] longitude, [63] zero
);

  logic                in_fire;
  logic                job_valid;
  ngga_pkg::ngga_job_t job;
  logic [30:0]         lat;
  logic [31:0]         lng;

  assign in_fire = in_tvalid && in_tready;

  // character-level parsing, one beat per cycle while in_tready is high
  ngga_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .rx_byte   (in_tdata),
    .job_valid (job_valid),
    .job       (job)
  );

  // end-of-line conversion; its last stage is the output register
  ngga_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (in_tready),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .lat       (lat),
    .lng       (lng)
  );

  assign out_tdata = {1'b0, lng, lat};

  // input only stalls once a result is held at the output
  a_stall_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[30:0]) <= 31'sd900000000) &&
                    ($signed(out_tdata[30:0]) >= -31'sd900000000)))
    else $error("latitude out of range");

  a_lng_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[62:31]) <= 32'sd1800000000) &&
                    ($signed(out_tdata[62:31]) >= -32'sd1800000000)))
    else $error("longitude out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[63])
    else $error("pad bit set");

endmodule
